// File: sv/yawsd_pkg.sv
// Shared types and constants of the yaw spring-damper follower.
package yawsd_pkg;

    localparam int ANGLE_W    = 16;
    localparam int SPEED_W    = 19;
    localparam int STEP_W     = 16;
    localparam int THR_W      = 15;
    localparam int GAIN_W     = 16;
    localparam int LIMIT_W    = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int FMAG_W     = 33;
    localparam int QUEUE_DEPTH = 2;

    // Angles in 1/128 degree, speeds in 1/128 degree per second
    localparam logic signed [19:0] HALF_TURN  = 20'sd23040;
    localparam logic signed [19:0] FULL_TURN  = 20'sd46080;
    localparam logic [17:0]        SPEED_MAX  = 18'd184320;
    localparam logic [17:0]        SNAP_SPEED = 18'd128;
    // ceil(2^24 / 10): exact floor division by ten for values below 2^22
    localparam logic [20:0]        RECIP_TEN  = 21'd1677722;

    // Register reset values
    localparam logic              RST_ENABLE = 1'b1;
    localparam logic [THR_W-1:0]  RST_START  = 15'd5760;
    localparam logic [THR_W-1:0]  RST_STOP   = 15'd640;
    localparam logic [THR_W-1:0]  RST_DEAD   = 15'd128;
    localparam logic [GAIN_W-1:0] RST_DAMP   = 16'd5120;
    localparam logic [GAIN_W-1:0] RST_SPRING = 16'd25600;
    localparam logic [LIMIT_W-1:0] RST_LIMIT = 18'd46080;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE,
        REG_START,
        REG_STOP,
        REG_DEAD,
        REG_DAMP,
        REG_SPRING,
        REG_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic               enable;
        logic [THR_W-1:0]   start_thr;
        logic [THR_W-1:0]   stop_thr;
        logic [THR_W-1:0]   dead_band;
        logic [GAIN_W-1:0]  damp_gain;
        logic [GAIN_W-1:0]  spring_gain;
        logic [LIMIT_W-1:0] speed_limit;
    } cfg_t;

    // One queued request with its precomputed decay factor
    typedef struct packed {
        logic [STEP_W-1:0]         time_step;
        logic signed [ANGLE_W-1:0] target_angle;
        logic [FMAG_W-1:0]         fmag;
        logic                      fneg;
    } job_t;

endpackage

// File: sv/yawsd_if.sv
// Request and result channel interfaces of the yaw spring-damper follower.
interface yawsd_in_if;
    import yawsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [STEP_W-1:0]         time_step;
    logic signed [ANGLE_W-1:0] target_angle;

    modport source (output valid, time_step, target_angle, input ready);
    modport sink (input valid, time_step, target_angle, output ready);
endinterface

interface yawsd_out_if;
    import yawsd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] current_angle;
    logic signed [SPEED_W-1:0] angular_speed;
    logic                      rotating;
    logic signed [ANGLE_W-1:0] angle_error;

    modport source (output valid, current_angle, angular_speed, rotating, angle_error,
                    input ready);
    modport sink (input valid, current_angle, angular_speed, rotating, angle_error,
                  output ready);
endinterface

// File: sv/yawsd_front.sv
// Front stage: take requests and precompute the idle decay factor.
module yawsd_front (
    input  logic            clk,
    input  logic            rst_n,
    input  yawsd_pkg::cfg_t cfg,
    yawsd_in_if.sink        ticks,
    output yawsd_pkg::job_t job,
    output logic            job_valid,
    input  logic            job_ready
);
    import yawsd_pkg::*;

    logic                      hold_valid_reg;
    logic [STEP_W-1:0]         dt_reg;
    logic signed [ANGLE_W-1:0] tgt_reg;
    logic [31:0]               damp_dt;
    logic signed [34:0]        factor;
    logic [34:0]               factor_abs;
    logic                      take;

    assign ticks.ready = !hold_valid_reg || job_ready;
    assign take        = ticks.valid && ticks.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (job_ready)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            dt_reg  <= ticks.time_step;
            tgt_reg <= ticks.target_angle;
        end
    end

    // factor = 1 - 2 * damping * dt, in Q.24
    assign damp_dt    = cfg.damp_gain * dt_reg;
    assign factor     = 35'sd16777216 - $signed({2'b00, damp_dt, 1'b0});
    assign factor_abs = factor[34] ? 35'(-factor) : 35'(factor);

    assign job_valid        = hold_valid_reg;
    assign job.time_step    = dt_reg;
    assign job.target_angle = tgt_reg;
    assign job.fmag         = factor_abs[FMAG_W-1:0];
    assign job.fneg         = factor[34];

endmodule

// File: sv/yawsd_queue.sv
// Short request queue between the front stage and the sequencer.
module yawsd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  yawsd_pkg::job_t push_data,
    input  logic            push_valid,
    output logic            push_ready,
    output yawsd_pkg::job_t pop_data,
    output logic            pop_valid,
    input  logic            pop_ready
);
    import yawsd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: sv/yawsd_back.sv
// Back end: sequencer with one shared multiplier that updates the kept yaw state.
module yawsd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  yawsd_pkg::cfg_t cfg,
    input  yawsd_pkg::job_t job,
    input  logic            job_valid,
    output logic            job_ready,
    yawsd_out_if.source     results
);
    import yawsd_pkg::*;

    localparam int WRAP_STEPS = 4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERROR,
        ST_DB_MUL,
        ST_DB_FIX,
        ST_DEC_LO,
        ST_DEC_HI,
        ST_DEC_FIX,
        ST_ROT_SPRING,
        ST_ROT_DAMP,
        ST_ROT_SUM,
        ST_ROT_LO,
        ST_ROT_HI,
        ST_ROT_SPEED,
        ST_ROT_MOVE,
        ST_ROT_YAW,
        ST_COMMIT
    } state_t;

    // Bring an angle back into [-180, +180]; both ends stay as they are
    function automatic logic signed [19:0] wrap_turn(input logic signed [19:0] a);
        logic signed [19:0] r;
        r = a;
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (r > HALF_TURN)
            begin
                r = r - FULL_TURN;
            end
            else if (r < -HALF_TURN)
            begin
                r = r + FULL_TURN;
            end
        end
        return r;
    endfunction

    state_t                    state_reg;
    logic [STEP_W-1:0]         dt_reg;
    logic signed [ANGLE_W-1:0] tgt_reg;
    logic [FMAG_W-1:0]         fmag_reg;
    logic                      fneg_reg;
    logic signed [ANGLE_W-1:0] yaw_reg;
    logic signed [SPEED_W-1:0] speed_reg;
    logic                      flag_reg;
    logic signed [ANGLE_W-1:0] err_reg;
    logic signed [ANGLE_W-1:0] yaw_new_reg;
    logic signed [SPEED_W-1:0] speed_new_reg;
    logic                      flag_new_reg;
    logic signed [ANGLE_W-1:0] err_new_reg;
    logic [THR_W-1:0]          emag_reg;
    logic                      eneg_reg;
    logic [17:0]               vmag_reg;
    logic                      vneg_reg;
    logic [41:0]               part_reg;
    logic [34:0]               acc_mag_reg;
    logic                      acc_neg_reg;
    logic                      out_valid_reg;

    logic [20:0]               mul_a;
    logic [20:0]               mul_b;
    logic [41:0]               prod_reg;

    logic signed [19:0]        diff_w;
    logic signed [19:0]        err_w;
    logic signed [19:0]        err_abs_w;
    logic [THR_W-1:0]          ae_w;
    logic signed [SPEED_W-1:0] speed_abs_w;
    logic                      flag_next_w;
    logic [17:0]               quot_w;
    logic [17:0]               db_mag_w;
    logic [SPEED_W-1:0]        db_speed_w;
    logic [51:0]               dec_total_w;
    logic [27:0]               dec_mag_w;
    logic [17:0]               dec_sat_w;
    logic [SPEED_W-1:0]        dec_speed_w;
    logic signed [36:0]        spr_w;
    logic signed [36:0]        dmp_w;
    logic signed [36:0]        acc_w;
    logic signed [36:0]        acc_abs_w;
    logic [51:0]               rot_total_w;
    logic [27:0]               rot_mag_w;
    logic signed [29:0]        delta_w;
    logic signed [29:0]        sum_w;
    logic [17:0]               lim_w;
    logic signed [29:0]        lim_s_w;
    logic signed [29:0]        clamp_w;
    logic signed [29:0]        clamp_abs_w;
    logic [17:0]               step_mag_w;
    logic signed [19:0]        step_w;
    logic signed [19:0]        yaw_sum_w;
    logic signed [19:0]        yaw_wrap_w;
    logic                      slot_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || results.ready;

    assign results.valid         = out_valid_reg;
    assign results.current_angle = yaw_reg;
    assign results.angular_speed = speed_reg;
    assign results.rotating      = flag_reg;
    assign results.angle_error   = err_reg;

    // Error and hysteresis
    assign diff_w      = $signed({{4{tgt_reg[ANGLE_W-1]}}, tgt_reg})
                       - $signed({{4{yaw_reg[ANGLE_W-1]}}, yaw_reg});
    assign err_w       = wrap_turn(diff_w);
    assign err_abs_w   = err_w[19] ? -err_w : err_w;
    assign ae_w        = err_abs_w[THR_W-1:0];
    assign speed_abs_w = speed_reg[SPEED_W-1] ? -speed_reg : speed_reg;
    assign flag_next_w = flag_reg ? !(ae_w < cfg.stop_thr) : (ae_w > cfg.start_thr);

    // Dead band: nine tenths, snap small speeds to zero
    assign quot_w     = prod_reg[41:24];
    assign db_mag_w   = (quot_w < SNAP_SPEED) ? '0 : quot_w;
    assign db_speed_w = vneg_reg ? SPEED_W'(-{1'b0, db_mag_w}) : {1'b0, db_mag_w};

    // Idle decay: speed times factor, saturated
    assign dec_total_w = {10'b0, part_reg} + {prod_reg[34:0], 17'b0};
    assign dec_mag_w   = dec_total_w[51:24];
    assign dec_sat_w   = (dec_mag_w > {10'b0, SPEED_MAX}) ? SPEED_MAX : dec_mag_w[17:0];
    assign dec_speed_w = (vneg_reg ^ fneg_reg) ? SPEED_W'(-{1'b0, dec_sat_w})
                                               : {1'b0, dec_sat_w};

    // Spring-damper acceleration
    assign spr_w     = eneg_reg ? -$signed({6'b0, part_reg[30:0]}) : $signed({6'b0, part_reg[30:0]});
    assign dmp_w     = vneg_reg ? -$signed({3'b0, prod_reg[33:0]}) : $signed({3'b0, prod_reg[33:0]});
    assign acc_w     = spr_w - dmp_w;
    assign acc_abs_w = acc_w[36] ? -acc_w : acc_w;

    // Speed integration and clamp
    assign rot_total_w = {10'b0, part_reg} + {1'b0, prod_reg[32:0], 18'b0};
    assign rot_mag_w   = rot_total_w[51:24];
    assign delta_w     = acc_neg_reg ? -$signed({2'b0, rot_mag_w}) : $signed({2'b0, rot_mag_w});
    assign sum_w       = $signed({{11{speed_reg[SPEED_W-1]}}, speed_reg}) + delta_w;
    assign lim_w       = (cfg.speed_limit > SPEED_MAX) ? SPEED_MAX : cfg.speed_limit;
    assign lim_s_w     = $signed({12'b0, lim_w});
    assign clamp_w     = (sum_w > lim_s_w) ? lim_s_w : ((sum_w < -lim_s_w) ? -lim_s_w : sum_w);
    assign clamp_abs_w = clamp_w[29] ? -clamp_w : clamp_w;

    // Angle integration
    assign step_mag_w = prod_reg[33:16];
    assign step_w     = vneg_reg ? -$signed({2'b0, step_mag_w}) : $signed({2'b0, step_mag_w});
    assign yaw_sum_w  = $signed({{4{yaw_reg[ANGLE_W-1]}}, yaw_reg}) + step_w;
    assign yaw_wrap_w = wrap_turn(yaw_sum_w);

    // Shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DB_MUL:
            begin
                mul_a = {3'b0, vmag_reg} + {vmag_reg, 3'b0};
                mul_b = RECIP_TEN;
            end
            ST_DEC_LO:
            begin
                mul_a = {3'b0, vmag_reg};
                mul_b = {4'b0, fmag_reg[16:0]};
            end
            ST_DEC_HI:
            begin
                mul_a = {3'b0, vmag_reg};
                mul_b = {5'b0, fmag_reg[32:17]};
            end
            ST_ROT_SPRING:
            begin
                mul_a = {5'b0, cfg.spring_gain};
                mul_b = {6'b0, emag_reg};
            end
            ST_ROT_DAMP:
            begin
                mul_a = {5'b0, cfg.damp_gain};
                mul_b = {3'b0, vmag_reg};
            end
            ST_ROT_LO:
            begin
                mul_a = {3'b0, acc_mag_reg[17:0]};
                mul_b = {5'b0, dt_reg};
            end
            ST_ROT_HI:
            begin
                mul_a = {4'b0, acc_mag_reg[34:18]};
                mul_b = {5'b0, dt_reg};
            end
            ST_ROT_MOVE:
            begin
                mul_a = {3'b0, vmag_reg};
                mul_b = {5'b0, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dt_reg        <= '0;
            tgt_reg       <= '0;
            fmag_reg      <= '0;
            fneg_reg      <= 1'b0;
            yaw_reg       <= '0;
            speed_reg     <= '0;
            flag_reg      <= 1'b0;
            err_reg       <= '0;
            yaw_new_reg   <= '0;
            speed_new_reg <= '0;
            flag_new_reg  <= 1'b0;
            err_new_reg   <= '0;
            emag_reg      <= '0;
            eneg_reg      <= 1'b0;
            vmag_reg      <= '0;
            vneg_reg      <= 1'b0;
            part_reg      <= '0;
            acc_mag_reg   <= '0;
            acc_neg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Raise valid on commit, drop it once the result is taken
            if ((state_reg == ST_COMMIT) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid)
                    begin
                        dt_reg        <= job.time_step;
                        tgt_reg       <= job.target_angle;
                        fmag_reg      <= job.fmag;
                        fneg_reg      <= job.fneg;
                        yaw_new_reg   <= yaw_reg;
                        speed_new_reg <= speed_reg;
                        flag_new_reg  <= flag_reg;
                        err_new_reg   <= err_reg;
                        state_reg     <= cfg.enable ? ST_ERROR : ST_COMMIT;
                    end
                end
                ST_ERROR:
                begin
                    err_new_reg  <= err_w[ANGLE_W-1:0];
                    flag_new_reg <= flag_next_w;
                    emag_reg     <= ae_w;
                    eneg_reg     <= err_w[19];
                    vmag_reg     <= speed_abs_w[17:0];
                    vneg_reg     <= speed_reg[SPEED_W-1];
                    if (ae_w < cfg.dead_band)
                    begin
                        state_reg <= ST_DB_MUL;
                    end
                    else if (!flag_next_w)
                    begin
                        state_reg <= ST_DEC_LO;
                    end
                    else
                    begin
                        state_reg <= ST_ROT_SPRING;
                    end
                end
                ST_DB_MUL:
                begin
                    state_reg <= ST_DB_FIX;
                end
                ST_DB_FIX:
                begin
                    speed_new_reg <= $signed(db_speed_w);
                    state_reg     <= ST_COMMIT;
                end
                ST_DEC_LO:
                begin
                    state_reg <= ST_DEC_HI;
                end
                ST_DEC_HI:
                begin
                    part_reg  <= prod_reg;
                    state_reg <= ST_DEC_FIX;
                end
                ST_DEC_FIX:
                begin
                    speed_new_reg <= $signed(dec_speed_w);
                    state_reg     <= ST_COMMIT;
                end
                ST_ROT_SPRING:
                begin
                    state_reg <= ST_ROT_DAMP;
                end
                ST_ROT_DAMP:
                begin
                    part_reg  <= prod_reg;
                    state_reg <= ST_ROT_SUM;
                end
                ST_ROT_SUM:
                begin
                    acc_mag_reg <= acc_abs_w[34:0];
                    acc_neg_reg <= acc_w[36];
                    state_reg   <= ST_ROT_LO;
                end
                ST_ROT_LO:
                begin
                    state_reg <= ST_ROT_HI;
                end
                ST_ROT_HI:
                begin
                    part_reg  <= prod_reg;
                    state_reg <= ST_ROT_SPEED;
                end
                ST_ROT_SPEED:
                begin
                    speed_new_reg <= clamp_w[SPEED_W-1:0];
                    vmag_reg      <= clamp_abs_w[17:0];
                    vneg_reg      <= clamp_w[29];
                    state_reg     <= ST_ROT_MOVE;
                end
                ST_ROT_MOVE:
                begin
                    state_reg <= ST_ROT_YAW;
                end
                ST_ROT_YAW:
                begin
                    yaw_new_reg <= yaw_wrap_w[ANGLE_W-1:0];
                    state_reg   <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (slot_free)
                    begin
                        yaw_reg   <= yaw_new_reg;
                        speed_reg <= speed_new_reg;
                        flag_reg  <= flag_new_reg;
                        err_reg   <= err_new_reg;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: sv/yaw_spring_damper_follower_core.sv
// Yaw spring-damper follower: top level with configuration registers.
// Path from request accept to result valid: front stage, queue, sequencer.
// The sequencer works on one request at a time (disabled, dead band, idle decay or
// rotating path) on its single shared 21x21 multiplier, and waits while a result is not taken.
// Reset: yaw, speed, flag and error clear to zero, registers take their defaults;
// the block takes requests as soon as reset is released, with no clearing pass.
module yaw_spring_damper_follower_core (
    input  logic                            clk,
    input  logic                            rst_n,
    yawsd_in_if.sink                        ticks,
    yawsd_out_if.source                     results,
    input  logic                            cfg_we,
    input  logic [yawsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [yawsd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import yawsd_pkg::*;

    cfg_t cfg_reg;
    job_t front_job;
    logic front_valid;
    logic front_ready;
    job_t queue_job;
    logic queue_valid;
    logic queue_ready;

    // Configuration registers: take a write whenever the enable is high and drop writes
    // to indexes beyond the register list. Software is to write them only while no request
    // is in flight, which the block does not enforce; the datapath reads them directly.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= RST_ENABLE;
            cfg_reg.start_thr   <= RST_START;
            cfg_reg.stop_thr    <= RST_STOP;
            cfg_reg.dead_band   <= RST_DEAD;
            cfg_reg.damp_gain   <= RST_DAMP;
            cfg_reg.spring_gain <= RST_SPRING;
            cfg_reg.speed_limit <= RST_LIMIT;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_ENABLE: cfg_reg.enable      <= cfg_data[0];
                REG_START:  cfg_reg.start_thr   <= cfg_data[THR_W-1:0];
                REG_STOP:   cfg_reg.stop_thr    <= cfg_data[THR_W-1:0];
                REG_DEAD:   cfg_reg.dead_band   <= cfg_data[THR_W-1:0];
                REG_DAMP:   cfg_reg.damp_gain   <= cfg_data[GAIN_W-1:0];
                REG_SPRING: cfg_reg.spring_gain <= cfg_data[GAIN_W-1:0];
                REG_LIMIT:  cfg_reg.speed_limit <= cfg_data[LIMIT_W-1:0];
                default:    cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Front stage: register each request and work out the idle decay
    // factor 1 - 2 * damping * dt, which needs no kept state.
    yawsd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ticks     (ticks),
        .job       (front_job),
        .job_valid (front_valid),
        .job_ready (front_ready)
    );

    // Queue: hold requests while the sequencer is busy so the request
    // channel keeps flowing.
    yawsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_job),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (queue_job),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    // Sequencer: when enabled, wrap the error, advance the hysteresis flag, then run the
    // dead band, idle decay or spring-damper path on the shared multiplier.
    // The kept state doubles as the result register; advance it only once the
    // previous result has been taken.
    yawsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (queue_job),
        .job_valid (queue_valid),
        .job_ready (queue_ready),
        .results   (results)
    );

endmodule

// File: test/tb_yaw_spring_damper_follower_core.sv
// Self-checking testbench for the yaw spring-damper follower core.
module tb_yaw_spring_damper_follower_core;
    timeunit 1ns;
    timeprecision 1ps;

    import yawsd_pkg::*;

    // One result as the block reports it
    typedef struct packed {
        logic signed [ANGLE_W-1:0] current_angle;
        logic signed [SPEED_W-1:0] angular_speed;
        logic                      rotating;
        logic signed [ANGLE_W-1:0] angle_error;
    } yaw_result_t;

    // One row of the directed plan: either a register write or a request,
    // the latter optionally carrying a result that is known by inspection
    typedef struct packed {
        logic                      is_write;
        reg_idx_t                  idx;
        logic [CFG_DATA_W-1:0]     val;
        logic [STEP_W-1:0]         dt;
        logic signed [ANGLE_W-1:0] tgt;
        logic                      known;
        yaw_result_t               want;
    } stim_row_t;

    // Fixed-point constants widened for the follower arithmetic
    localparam longint HALF     = longint'(HALF_TURN);
    localparam longint FULL     = longint'(FULL_TURN);
    localparam longint TOP_RATE = longint'(SPEED_MAX);
    localparam longint SNAP     = longint'(SNAP_SPEED);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    yawsd_in_if  tick_ch ();
    yawsd_out_if result_ch ();

    yaw_spring_damper_follower_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ticks     (tick_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Shadow of the register file and of the kept follower state
    cfg_t   cfg_now;
    longint yaw_angle = 0;
    longint yaw_rate  = 0;
    longint err_kept  = 0;
    logic   turning   = 1'b0;

    // Results still owed by the block, oldest first
    yaw_result_t owed_results[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned ticks_live    = 0;
    int unsigned ticks_idle    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned settings_used = 0;

    // Bring an angle back into [-180, +180]; both ends stay as they are
    function automatic longint wrap_half_turn(longint a);
        while (a > HALF) a -= FULL;
        while (a < -HALF) a += FULL;
        return a;
    endfunction

    // a * b / 2^sh with the magnitude truncated, so rounding is toward zero
    function automatic longint scaled_toward_zero(longint a, longint b, int sh);
        longint m;
        m = ((a < 0 ? -a : a) * b) >> sh;
        return a < 0 ? -m : m;
    endfunction

    function automatic longint limit_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Advance the follower by one tick and return what it should report
    function automatic yaw_result_t follow_target(logic [STEP_W-1:0] dt_raw,
                                                  logic signed [ANGLE_W-1:0] tgt);
        longint      dt;
        longint      k_damp;
        longint      k_spring;
        longint      lim;
        longint      err;
        longint      mag_err;
        longint      spd;
        longint      fct;
        longint      acc;
        yaw_result_t r;
        dt       = longint'(dt_raw);
        k_damp   = longint'(cfg_now.damp_gain);
        k_spring = longint'(cfg_now.spring_gain);
        lim      = longint'(cfg_now.speed_limit);
        if (lim > TOP_RATE) lim = TOP_RATE;
        if (cfg_now.enable) begin
            err      = wrap_half_turn(longint'(tgt) - yaw_angle);
            mag_err  = err < 0 ? -err : err;
            err_kept = err;
            // Hysteresis: strict comparisons on both thresholds
            if (!turning) begin
                if (mag_err > longint'(cfg_now.start_thr)) turning = 1'b1;
            end
            else begin
                if (mag_err < longint'(cfg_now.stop_thr)) turning = 1'b0;
            end
            if (mag_err < longint'(cfg_now.dead_band)) begin
                // Decay by nine tenths, snap to rest below 1 deg/s
                spd = (yaw_rate * 9) / 10;
                if ((spd < 0 ? -spd : spd) < SNAP) spd = 0;
                yaw_rate = spd;
            end
            else if (!turning) begin
                // Damping only: factor 1 - 2*damp*dt in Q.24, may go negative
                fct = (longint'(1) << 24) - 2 * k_damp * dt;
                spd = scaled_toward_zero(yaw_rate, fct < 0 ? -fct : fct, 24);
                if (fct < 0) spd = -spd;
                yaw_rate = limit_mag(spd, TOP_RATE);
            end
            else begin
                acc       = k_spring * err - k_damp * yaw_rate;
                spd       = limit_mag(yaw_rate + scaled_toward_zero(acc, dt, 24), lim);
                yaw_rate  = spd;
                yaw_angle = wrap_half_turn(yaw_angle + scaled_toward_zero(spd, dt, 16));
            end
        end
        r.current_angle = yaw_angle[ANGLE_W-1:0];
        r.angular_speed = yaw_rate[SPEED_W-1:0];
        r.rotating      = turning;
        r.angle_error   = err_kept[ANGLE_W-1:0];
        return r;
    endfunction

    // Usually a value from the working range, now and then one of two extremes
    function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
                                                 int unsigned rare_lo, int unsigned rare_hi);
        if ($urandom_range(5) == 0) return $urandom_range(1) ? rare_hi : rare_lo;
        return $urandom_range(hi, lo);
    endfunction

    function automatic stim_row_t tick_row(logic [STEP_W-1:0] dt,
                                           logic signed [ANGLE_W-1:0] tgt);
        stim_row_t r;
        r     = '0;
        r.dt  = dt;
        r.tgt = tgt;
        return r;
    endfunction

    function automatic stim_row_t known_row(logic [STEP_W-1:0] dt,
                                            logic signed [ANGLE_W-1:0] tgt,
                                            logic signed [ANGLE_W-1:0] ang,
                                            logic signed [SPEED_W-1:0] spd,
                                            logic rot,
                                            logic signed [ANGLE_W-1:0] err);
        stim_row_t r;
        r                    = tick_row(dt, tgt);
        r.known              = 1'b1;
        r.want.current_angle = ang;
        r.want.angular_speed = spd;
        r.want.rotating      = rot;
        r.want.angle_error   = err;
        return r;
    endfunction

    function automatic stim_row_t reg_row(reg_idx_t idx, int unsigned val);
        stim_row_t r;
        r          = '0;
        r.is_write = 1'b1;
        r.idx      = idx;
        r.val      = val[CFG_DATA_W-1:0];
        return r;
    endfunction

    // Offer one request, idling first at the current rate, and record what
    // the block owes for it once it is taken. Valid is left high on return so
    // that a following request can go out back to back.
    task automatic send_tick(input logic [STEP_W-1:0] dt,
                             input logic signed [ANGLE_W-1:0] tgt,
                             input logic known = 1'b0,
                             input yaw_result_t want = '0);
        yaw_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.time_step    <= dt;
        tick_ch.target_angle <= tgt;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        if (cfg_now.enable) ticks_live++;
        else ticks_idle++;
        r = follow_target(dt, tgt);
        owed_results.push_back(known ? want : r);
    endtask

    // Drop valid and hold until every owed result has come back
    task automatic settle();
        tick_ch.valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk);
    endtask

    // Registers change only with the block idle; after the write the enable
    // drops again before anything else goes out
    task automatic write_reg(input reg_idx_t idx, input int unsigned val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ENABLE: cfg_now.enable      = val[0];
            REG_START:  cfg_now.start_thr   = val[THR_W-1:0];
            REG_STOP:   cfg_now.stop_thr    = val[THR_W-1:0];
            REG_DEAD:   cfg_now.dead_band   = val[THR_W-1:0];
            REG_DAMP:   cfg_now.damp_gain   = val[GAIN_W-1:0];
            REG_SPRING: cfg_now.spring_gain = val[GAIN_W-1:0];
            REG_LIMIT:  cfg_now.speed_limit = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Result side: compare each taken result with the oldest owed one, then
    // decide whether to stall the next cycle
    always @(posedge clk)
    begin : drain_results
        yaw_result_t w;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            results_seen++;
            if (owed_results.size() == 0) begin
                $error("result with no request outstanding: angle %0d speed %0d",
                       result_ch.current_angle, result_ch.angular_speed);
                mismatches++;
            end
            else begin
                w = owed_results.pop_front();
                if (result_ch.current_angle !== w.current_angle) begin
                    $error("current_angle: expected %0d, got %0d",
                           w.current_angle, result_ch.current_angle);
                    mismatches++;
                end
                if (result_ch.angular_speed !== w.angular_speed) begin
                    $error("angular_speed: expected %0d, got %0d",
                           w.angular_speed, result_ch.angular_speed);
                    mismatches++;
                end
                if (result_ch.rotating !== w.rotating) begin
                    $error("rotating: expected %0d, got %0d",
                           w.rotating, result_ch.rotating);
                    mismatches++;
                end
                if (result_ch.angle_error !== w.angle_error) begin
                    $error("angle_error: expected %0d, got %0d",
                           w.angle_error, result_ch.angle_error);
                    mismatches++;
                end
            end
        end
        result_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #10ms;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        stim_row_t   plan[$];
        stim_row_t   row;
        int unsigned reg_val[7];
        int unsigned phase_end;
        int unsigned sel;
        int unsigned len;
        int unsigned base;
        int unsigned goal;
        int          aim;
        int          sgn;

        // Known levels on the request and register inputs from time zero;
        // the result side's ready follows from the first edge
        tick_ch.valid        <= 1'b0;
        tick_ch.time_step    <= '0;
        tick_ch.target_angle <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= REG_ENABLE;
        cfg_data             <= '0;
        rst_n                <= 1'b0;

        cfg_now.enable      = RST_ENABLE;
        cfg_now.start_thr   = RST_START;
        cfg_now.stop_thr    = RST_STOP;
        cfg_now.dead_band   = RST_DEAD;
        cfg_now.damp_gain   = RST_DAMP;
        cfg_now.spring_gain = RST_SPRING;
        cfg_now.speed_limit = RST_LIMIT;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed plan. Straight after reset nothing moves with a zero step;
        // a half-turn target exceeds the start threshold at once and stays at
        // +180 or -180 without being wrapped.
        plan.push_back(known_row(16'd0, 16'sd0, 16'sd0, 19'sd0, 1'b0, 16'sd0));
        plan.push_back(known_row(16'd0, 16'sd23040, 16'sd0, 19'sd0, 1'b1, 16'sd23040));
        plan.push_back(known_row(16'd0, -16'sd23040, 16'sd0, 19'sd0, 1'b1, -16'sd23040));
        // Targets beyond a half turn, taken as two's complement and wrapped
        plan.push_back(tick_row(16'd0, 16'sd32767));
        plan.push_back(tick_row(16'd0, -16'sd32768));
        // Longest step, then a short glide toward a held target
        plan.push_back(tick_row(16'd65535, 16'sd23040));
        repeat (6) plan.push_back(tick_row(16'd1311, 16'sd2560));
        // Disabled: the result repeats the kept state
        plan.push_back(reg_row(REG_ENABLE, 0));
        plan.push_back(tick_row(16'd65535, -16'sd23040));
        plan.push_back(reg_row(REG_ENABLE, 1));
        // Thresholds beyond a half turn: start never fires, stop always does,
        // so only damping applies; with a long step the factor goes negative
        plan.push_back(reg_row(REG_START, 32767));
        plan.push_back(reg_row(REG_STOP, 32767));
        plan.push_back(tick_row(16'd65535, -16'sd11520));
        plan.push_back(reg_row(REG_DAMP, 65535));
        plan.push_back(tick_row(16'd65535, 16'sd11520));
        // Dead band over everything: nine-tenths decay and snap to rest
        plan.push_back(reg_row(REG_DEAD, 32767));
        plan.push_back(tick_row(16'd1000, 16'sd0));
        plan.push_back(tick_row(16'd1000, 16'sd5000));
        // Undamped maximum spring, speed limit above the hard ceiling
        plan.push_back(reg_row(REG_DEAD, 0));
        plan.push_back(reg_row(REG_START, 0));
        plan.push_back(reg_row(REG_STOP, 0));
        plan.push_back(reg_row(REG_DAMP, 0));
        plan.push_back(reg_row(REG_SPRING, 65535));
        plan.push_back(reg_row(REG_LIMIT, 262143));
        plan.push_back(tick_row(16'd65535, 16'sd23040));
        plan.push_back(tick_row(16'd65535, -16'sd23040));
        // Zero speed limit pins the speed at rest
        plan.push_back(reg_row(REG_LIMIT, 0));
        plan.push_back(tick_row(16'd655, 16'sd100));

        send_idle_pct = 31;
        recv_idle_pct = 66;
        foreach (plan[i]) begin
            row = plan[i];
            if (row.is_write) write_reg(row.idx, row.val);
            else send_tick(row.dt, row.tgt, row.known, row.want);
        end

        // Random part: three idling mixes, each a series of register settings
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 31; recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 31; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            goal = ticks_live + 650;
            while (ticks_live < goal) begin
                // Open with two extreme settings, then draw the rest
                if (settings_used == 0) reg_val = '{1, 0, 0, 0, 0, 65535, 262143};
                else if (settings_used == 1) reg_val = '{1, 32767, 0, 0, 65535, 0, 0};
                else begin
                    reg_val[0] = ($urandom_range(9) != 0);
                    reg_val[1] = pick_setting(0, 11520, 0, 32767);
                    reg_val[2] = pick_setting(0, reg_val[1], 0, 32767);
                    reg_val[3] = pick_setting(0, 1280, 0, 32767);
                    reg_val[4] = pick_setting(0, 12800, 0, 65535);
                    reg_val[5] = pick_setting(0, 51200, 0, 65535);
                    reg_val[6] = pick_setting(0, 184320, 0, 262143);
                end
                for (int i = 0; i < 7; i++) write_reg(reg_idx_t'(i), reg_val[i]);
                settings_used++;

                phase_end = ticks_live + ticks_idle
                            + (reg_val[0] ? $urandom_range(90, 40) : 4);
                while (ticks_live + ticks_idle < phase_end) begin
                    sel = reg_val[0] ? $urandom_range(9) : 7;
                    if (sel <= 6) begin
                        // Glide toward a held target with a steady frame time
                        aim  = int'($urandom_range(46080)) - 23040;
                        base = $urandom_range(3000, 64);
                        len  = $urandom_range(30, 4);
                        for (int k = 0; k < len; k++)
                            send_tick(STEP_W'(base + $urandom_range(63)),
                                      ANGLE_W'(($urandom_range(7) == 0)
                                          ? aim + int'($urandom_range(256)) - 128 : aim));
                    end
                    else if (sel == 7) begin
                        // Noise over the full width of both fields
                        len = $urandom_range(3, 1);
                        for (int k = 0; k < len; k++)
                            send_tick(STEP_W'($urandom_range(65535)),
                                      ANGLE_W'($urandom_range(65535)));
                    end
                    else if (sel == 8) begin
                        // Field extremes
                        case ($urandom_range(4))
                            0: aim = 23040;
                            1: aim = -23040;
                            2: aim = 32767;
                            3: aim = -32768;
                            default: aim = 0;
                        endcase
                        case ($urandom_range(2))
                            0: base = 0;
                            1: base = 1;
                            default: base = 65535;
                        endcase
                        send_tick(STEP_W'(base), ANGLE_W'(aim));
                    end
                    else begin
                        // Swing the target across the +-180 seam to force wraps
                        len = $urandom_range(10, 3);
                        sgn = $urandom_range(1) ? 1 : -1;
                        for (int k = 0; k < len; k++) begin
                            send_tick(STEP_W'($urandom_range(65535, 2000)),
                                      ANGLE_W'(sgn * (23040 - int'($urandom_range(640)))));
                            sgn = -sgn;
                        end
                    end
                end
            end
        end

        // Drain, then allow a full latency for any stray result to show up
        settle();
        repeat (40) @(posedge clk);

        $display("Covered %0d requests with motion enabled and %0d disabled, %0d results checked",
                 ticks_live, ticks_idle, results_seen);
        $display("Register settings drawn: %0d, under three idling mixes on both channels",
                 settings_used);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
